/* src/lse_pkg.sv */
// ----------------------------------------------------------------------------
// lse_pkg: shared types, constants and tables of the LED strip effect engine
// Register indexes, effect codes, sine table, hue conversion and xorshift.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_RED   = 3'd1;
  localparam logic [2:0] REG_GREEN = 3'd2;
  localparam logic [2:0] REG_BLUE  = 3'd3;
  localparam logic [2:0] REG_COUNT = 3'd4;

  // effect codes
  localparam logic [2:0] EFF_STATIC  = 3'd0;
  localparam logic [2:0] EFF_BREATH  = 3'd1;
  localparam logic [2:0] EFF_CYCLE   = 3'd2;
  localparam logic [2:0] EFF_RAINBOW = 3'd3;
  localparam logic [2:0] EFF_WAVE    = 3'd4;
  localparam logic [2:0] EFF_SPARKLE = 3'd5;

  localparam logic [15:0] RAND_SEED   = 16'hACED;
  localparam logic [7:0]  DECAY_MUL   = 8'd217;
  localparam logic [7:0]  SMOOTH_MUL  = 8'd77;
  localparam logic [7:0]  FULL        = 8'd255;
  // sine phase: 255/120 is 17/8 and 255/60 is 17/4, so a multiply and a shift
  localparam logic [7:0]  PHASE_MUL   = 8'd17;
  localparam logic [7:0]  SPARK_LIMIT = 8'd8;

  // operations run through the shared multiply / divide unit
  typedef enum logic [2:0] {
    OP_OFFSET,
    OP_PHASE,
    OP_TGT,
    OP_LVL,
    OP_VAL,
    OP_RED,
    OP_GREEN,
    OP_BLUE
  } op_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam logic [7:0] SINE_LUT [256] = '{
    8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,
    8'd152,8'd155,8'd158,8'd162,8'd165,8'd167,8'd170,8'd173,
    8'd176,8'd179,8'd182,8'd185,8'd188,8'd190,8'd193,8'd196,
    8'd198,8'd201,8'd203,8'd206,8'd208,8'd211,8'd213,8'd215,
    8'd218,8'd220,8'd222,8'd224,8'd226,8'd228,8'd230,8'd232,
    8'd234,8'd235,8'd237,8'd239,8'd240,8'd241,8'd243,8'd244,
    8'd245,8'd246,8'd248,8'd249,8'd250,8'd250,8'd251,8'd252,
    8'd253,8'd253,8'd254,8'd254,8'd254,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd254,8'd253,
    8'd253,8'd252,8'd251,8'd250,8'd250,8'd249,8'd248,8'd246,
    8'd245,8'd244,8'd243,8'd241,8'd240,8'd239,8'd237,8'd235,
    8'd234,8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,8'd220,
    8'd218,8'd215,8'd213,8'd211,8'd208,8'd206,8'd203,8'd201,
    8'd198,8'd196,8'd193,8'd190,8'd188,8'd185,8'd182,8'd179,
    8'd176,8'd173,8'd170,8'd167,8'd165,8'd162,8'd158,8'd155,
    8'd152,8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,8'd131,
    8'd128,8'd124,8'd121,8'd118,8'd115,8'd112,8'd109,8'd106,
    8'd103,8'd100,8'd97, 8'd93, 8'd90, 8'd88, 8'd85, 8'd82,
    8'd79, 8'd76, 8'd73, 8'd70, 8'd67, 8'd65, 8'd62, 8'd59,
    8'd57, 8'd54, 8'd52, 8'd49, 8'd47, 8'd44, 8'd42, 8'd40,
    8'd37, 8'd35, 8'd33, 8'd31, 8'd29, 8'd27, 8'd25, 8'd23,
    8'd21, 8'd20, 8'd18, 8'd16, 8'd15, 8'd14, 8'd12, 8'd11,
    8'd10, 8'd9,  8'd7,  8'd6,  8'd5,  8'd5,  8'd4,  8'd3,
    8'd2,  8'd2,  8'd1,  8'd1,  8'd1,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,  8'd1,  8'd2,
    8'd2,  8'd3,  8'd4,  8'd5,  8'd5,  8'd6,  8'd7,  8'd9,
    8'd10, 8'd11, 8'd12, 8'd14, 8'd15, 8'd16, 8'd18, 8'd20,
    8'd21, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd35,
    8'd37, 8'd40, 8'd42, 8'd44, 8'd47, 8'd49, 8'd52, 8'd54,
    8'd57, 8'd59, 8'd62, 8'd65, 8'd67, 8'd70, 8'd73, 8'd76,
    8'd79, 8'd82, 8'd85, 8'd88, 8'd90, 8'd93, 8'd97, 8'd100,
    8'd103,8'd106,8'd109,8'd112,8'd115,8'd118,8'd121,8'd124
  };

  // full saturation, full value hue wheel: p is 0, q is 255-frac, t is frac
  function automatic rgb_t hue_wheel(input logic [7:0] h);
    logic [7:0] base;
    logic [7:0] frac;
    logic [2:0] sector;
    rgb_t       c;
    if (h < 8'd43) begin
      sector = 3'd0; base = 8'd0;
    end else if (h < 8'd86) begin
      sector = 3'd1; base = 8'd43;
    end else if (h < 8'd129) begin
      sector = 3'd2; base = 8'd86;
    end else if (h < 8'd172) begin
      sector = 3'd3; base = 8'd129;
    end else if (h < 8'd215) begin
      sector = 3'd4; base = 8'd172;
    end else begin
      sector = 3'd5; base = 8'd215;
    end
    frac = 8'((h - base) * 8'd6);
    case (sector)
      3'd0:    c = '{r: FULL, g: frac, b: 8'd0};
      3'd1:    c = '{r: FULL - frac, g: FULL, b: 8'd0};
      3'd2:    c = '{r: 8'd0, g: FULL, b: frac};
      3'd3:    c = '{r: 8'd0, g: FULL - frac, b: FULL};
      3'd4:    c = '{r: frac, g: 8'd0, b: FULL};
      default: c = '{r: FULL, g: 8'd0, b: FULL - frac};
    endcase
    return c;
  endfunction

  function automatic logic [15:0] xorshift16(input logic [15:0] s);
    logic [15:0] x;
    x = s ^ (s << 7);
    x = x ^ (x >> 9);
    x = x ^ (x << 8);
    return x;
  endfunction

endpackage

`default_nettype wire

/* src/lse_ram.sv */
// ----------------------------------------------------------------------------
// lse_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/lse_div.sv */
// ----------------------------------------------------------------------------
// lse_div: 16 by 8 restoring divider, one quotient bit a cycle
// Expects the quotient to fit 8 bits; done pulses after eight steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_div
  import lse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [7:0]  divisor_i,
  output logic             done_o,
  output logic [7:0]       quot_o
);

  logic [7:0] rem_q, rem_d, quo_q, quo_d, dsr_q;
  logic [2:0] cnt_q;
  logic       busy_q, done_q;
  logic [8:0] trial;
  logic       ge;

  always_comb begin
    trial = {rem_q, quo_q[7]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
    quo_d = {quo_q[6:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[15:8];
      quo_q <= dividend_i[7:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* src/led_strip_effect_generator.sv */
// ----------------------------------------------------------------------------
// led_strip_effect_generator: per-LED RGB effect engine
// Static, breathing, colour cycle, rainbow, wave and sparkle effects.
// ----------------------------------------------------------------------------
// Steps per item: every effect ends with value, red, green and blue
//   multiply steps; breathing puts the sine phase first, sparkle a level
//   step (on decay after a target step), rainbow the position offset and
//   wave the offset and the phase. The offset uses the divider, all others
//   the single shared 8x8 multiplier; a new item waits for the last result.
// Reset: base colour 0/255/0, 66 LEDs, static mode, seed 0xACED, sparkle
//   stores empty (per-LED valid bits, also cleared by a mode write).
`default_nettype none

module led_strip_effect_generator
  import lse_pkg::*;
#(
  parameter int MAX_LEDS = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  // input items
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] led_brightness_i,
  input  wire logic       brightness_used_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic [6:0]      led_index_o,
  output logic            frame_last_o
);

  localparam int PW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  // configuration
  logic [2:0] mode_q;
  logic [7:0] base_r_q, base_g_q, base_b_q, count_q;

  // frame state: full tick plus its residues for the two sine periods
  logic [31:0]   tick_q;
  logic [6:0]    tick120_q;
  logic [5:0]    tick60_q;
  logic [PW-1:0] position_q;
  logic [15:0]   rand_q;
  logic [MAX_LEDS-1:0] spark_vld_q;

  // item state
  logic [PW-1:0] pos_q;
  logic          last_q;
  logic [7:0]    n_q, bright_q;
  logic          used_q;
  logic [7:0]    offset_q, anim_q, val_q, tgt_q, lvl_q;
  rgb_t          col_q;

  // result register
  logic       out_vld_q;
  rgb_t       out_col_q;
  logic [6:0] out_idx_q;
  logic       out_last_q;

  logic accept;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // strip position for the item being accepted
  logic [7:0]    n_eff;
  logic [PW-1:0] pos_new;
  logic          last_new;
  always_comb begin
    n_eff = (count_q == 8'd0) ? 8'd1 : count_q;
    if (11'(n_eff) > 11'(MAX_LEDS)) begin
      n_eff = 8'(MAX_LEDS);
    end
    pos_new  = (11'(position_q) >= 11'(n_eff)) ? '0 : position_q;
    last_new = (11'(pos_new) == 11'(n_eff) - 11'd1);
  end

  // sparkle store: {target, level} per LED
  logic        ram_we;
  logic [15:0] ram_rdata;
  logic [7:0]  lvl_next;

  lse_ram #(
    .WIDTH(16),
    .DEPTH(MAX_LEDS)
  ) u_spark_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i({tgt_q, lvl_next}),
    .re_i   (accept),
    .raddr_i(pos_new),
    .rdata_o(ram_rdata)
  );

  // shared multiplier: product registered in the issue cycle, then divided
  // by 255 as (x + (x >> 8) + 1) >> 8, exact for every product below 65280
  logic        div_start, div_done;
  logic [7:0]  div_quot, mul_a, mul_b;
  logic [15:0] prod_q;
  logic [7:0]  quot255, phase, res;
  logic        step_done;
  logic [8:0]  diff;
  logic [7:0]  diff_abs;

  always_comb begin
    diff     = {1'b0, tgt_q} - {1'b0, lvl_q};
    diff_abs = diff[8] ? 8'(-diff) : diff[7:0];
    mul_a    = 8'd0;
    mul_b    = 8'd0;
    case (op_q)
      OP_PHASE: begin
        mul_a = (mode_q == EFF_BREATH) ? {1'b0, tick120_q} : {2'b0, tick60_q};
        mul_b = PHASE_MUL;
      end
      OP_TGT: begin
        mul_a = tgt_q;
        mul_b = DECAY_MUL;
      end
      OP_LVL: begin
        mul_a = diff_abs;
        mul_b = SMOOTH_MUL;
      end
      OP_VAL: begin
        mul_a = anim_q;
        mul_b = used_q ? bright_q : FULL;
      end
      OP_RED: begin
        mul_a = col_q.r;
        mul_b = val_q;
      end
      OP_GREEN: begin
        mul_a = col_q.g;
        mul_b = val_q;
      end
      OP_BLUE: begin
        mul_a = col_q.b;
        mul_b = val_q;
      end
      default: ;   // offset goes through the divider
    endcase
    quot255   = 8'((prod_q + {8'd0, prod_q[15:8]} + 16'd1) >> 8);
    // tick*255/120 is tick*17/8, tick*255/60 is tick*17/4
    phase     = (mode_q == EFF_BREATH) ? prod_q[10:3] : prod_q[9:2];
    res       = (op_q == OP_OFFSET) ? div_quot :
                (op_q == OP_PHASE)  ? phase : quot255;
    step_done = (op_q == OP_OFFSET) ? div_done : 1'b1;
    div_start = (state_q == S_ISSUE) && (op_q == OP_OFFSET);
  end

  lse_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({8'(pos_q), 8'h00}),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign lvl_next = diff[8] ? lvl_q - res : lvl_q + res;
  assign ram_we   = (state_q == S_WAIT) && step_done && (op_q == OP_LVL);

  // sparkle entry as read back; never-written entries read as zero
  logic       spark_hit;
  logic [7:0] tgt_rd, lvl_rd;
  assign spark_hit = spark_vld_q[pos_q];
  assign tgt_rd    = spark_hit ? ram_rdata[15:8] : 8'd0;
  assign lvl_rd    = spark_hit ? ram_rdata[7:0] : 8'd0;

  logic out_free;
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_PREP;
      S_PREP: begin
        state_d = S_ISSUE;
        case (mode_q) inside
          EFF_BREATH:            op_d = OP_PHASE;
          EFF_RAINBOW, EFF_WAVE: op_d = OP_OFFSET;
          EFF_SPARKLE:           op_d = (rand_q[7:0] < SPARK_LIMIT) ? OP_LVL : OP_TGT;
          default:               op_d = OP_VAL;
        endcase
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (step_done) begin
          state_d = S_ISSUE;
          case (op_q)
            OP_OFFSET: op_d = (mode_q == EFF_RAINBOW) ? OP_VAL : OP_PHASE;
            OP_TGT:    op_d = OP_LVL;
            OP_VAL:    op_d = OP_RED;
            OP_RED:    op_d = OP_GREEN;
            OP_GREEN:  op_d = OP_BLUE;
            OP_BLUE:   state_d = S_DONE;
            default:   op_d = OP_VAL;   // phase and level feed the brightness
          endcase
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_VAL;
      mode_q      <= EFF_STATIC;
      base_r_q    <= 8'd0;
      base_g_q    <= 8'd255;
      base_b_q    <= 8'd0;
      count_q     <= 8'd66;
      tick_q      <= '0;
      tick120_q   <= '0;
      tick60_q    <= '0;
      position_q  <= '0;
      rand_q      <= RAND_SEED;
      spark_vld_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE: begin
            mode_q      <= cfg_data_i[2:0];
            tick_q      <= '0;
            tick120_q   <= '0;
            tick60_q    <= '0;
            spark_vld_q <= '0;
          end
          REG_RED:   base_r_q <= cfg_data_i;
          REG_GREEN: base_g_q <= cfg_data_i;
          REG_BLUE:  base_b_q <= cfg_data_i;
          REG_COUNT: count_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        position_q <= last_new ? '0 : pos_new + PW'(1);
        if (pos_new == '0) begin
          tick_q <= tick_q + 32'd1;
          // tick wraps to zero, so both residues restart
          if (tick_q == '1) begin
            tick120_q <= '0;
            tick60_q  <= '0;
          end else begin
            tick120_q <= (tick120_q == 7'd119) ? 7'd0 : tick120_q + 7'd1;
            tick60_q  <= (tick60_q == 6'd59) ? 6'd0 : tick60_q + 6'd1;
          end
        end
        if (mode_q == EFF_SPARKLE) begin
          rand_q <= xorshift16(rand_q);
        end
      end
      if (ram_we) begin
        spark_vld_q[pos_q] <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q    <= pos_new;
      last_q   <= last_new;
      n_q      <= n_eff;
      bright_q <= led_brightness_i;
      used_q   <= brightness_used_i;
    end
    if (state_q == S_PREP) begin
      anim_q <= FULL;
      col_q  <= (mode_q == EFF_CYCLE) ? hue_wheel({tick_q[6:0], 1'b0})
                                      : '{r: base_r_q, g: base_g_q, b: base_b_q};
      lvl_q  <= lvl_rd;
      tgt_q  <= (rand_q[7:0] < SPARK_LIMIT) ? FULL : tgt_rd;
    end
    if (state_q == S_ISSUE) begin
      prod_q <= 16'(mul_a) * 16'(mul_b);
    end
    if (state_q == S_WAIT && step_done) begin
      case (op_q)
        OP_OFFSET: begin
          offset_q <= res;
          if (mode_q == EFF_RAINBOW) begin
            col_q <= hue_wheel({tick_q[6:0], 1'b0} + res);
          end
        end
        OP_PHASE: anim_q <= (mode_q == EFF_WAVE) ? SINE_LUT[res + offset_q]
                                                  : SINE_LUT[res];
        OP_TGT: tgt_q <= res;
        OP_LVL: anim_q <= lvl_next;
        OP_VAL: val_q <= res;
        OP_RED: col_q.r <= res;
        OP_GREEN: col_q.g <= res;
        default: col_q.b <= res;
      endcase
    end
    if (state_q == S_DONE && out_free) begin
      out_col_q  <= col_q;
      out_idx_q  <= 7'(pos_q);
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign red_o        = out_col_q.r;
  assign green_o      = out_col_q.g;
  assign blue_o       = out_col_q.b;
  assign led_index_o  = out_idx_q;
  assign frame_last_o = out_last_q;

endmodule

`default_nettype wire
